// File: design/spwm_pkg.sv
// shared types, register codes and arithmetic constants for the sine pwm compare generator
`timescale 1ns / 1ps
package spwm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_STEP   = 3'd0,
    REG_MOD_INDEX    = 3'd1,
    REG_LEG_B_OFFSET = 3'd2,
    REG_PERIOD       = 3'd3,
    REG_BRIDGE_DEG   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] angle_step;
    logic [15:0] modulation_index;
    logic [15:0] leg_b_offset;
    logic [15:0] period_counts;
    logic [7:0]  bridge_phase_deg;
  } cfg_t;

  localparam logic [31:0] RST_ANGLE_STEP = 32'd368440757;
  localparam logic [15:0] RST_PERIOD     = 16'd98;
  localparam logic [7:0]  RST_BRIDGE_DEG = 8'd180;

  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] SINE_FULL   = 32'd32767;
  localparam logic [46:0] MAG_ROUND   = 47'h0000_2000_0000;

  // floor(y/180) = (y * RECIP_180) >> 32 exactly for y below 2^24
  localparam logic [31:0] RECIP_180 = 32'(((64'd1 << 32) + 64'd179) / 64'd180);

  // taylor series divisors, highest order first
  localparam int          NUM_TERMS = 5;
  localparam logic [31:0] RECIP_110 = 32'((64'd1 << 32) / 64'd110);
  localparam logic [31:0] RECIP_72  = 32'((64'd1 << 32) / 64'd72);
  localparam logic [31:0] RECIP_42  = 32'((64'd1 << 32) / 64'd42);
  localparam logic [31:0] RECIP_20  = 32'((64'd1 << 32) / 64'd20);
  localparam logic [31:0] RECIP_6   = 32'((64'd1 << 32) / 64'd6);

  function automatic logic [31:0] term_div(logic [2:0] i);
    logic [31:0] d;
    unique case (i)
      3'd0:    d = 32'd110;
      3'd1:    d = 32'd72;
      3'd2:    d = 32'd42;
      3'd3:    d = 32'd20;
      default: d = 32'd6;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] term_recip(logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0:    r = RECIP_110;
      3'd1:    r = RECIP_72;
      3'd2:    r = RECIP_42;
      3'd3:    r = RECIP_20;
      default: r = RECIP_6;
    endcase
    return r;
  endfunction

endpackage

// File: design/sine_pwm_compare_generator_unit.sv
// top level: config registers, sequencer, shared multiplier and sine table
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  cfg     | in        | cfg_write              | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall    | tick
//  out     | out       | out_valid / out_stall  | compare_leg_a, compare_leg_b, phase_load
//
// after reset the sine table is built by the shared multiplier, one entry at a time,
// through SINE_TABLE_DEPTH entries in all; in_stall stays high meanwhile
// each word then steps from acceptance to a filled output register, one shared
// multiply per step, and no new word is taken until the last one has left its final step
// the output register holds a finished word while out_stall is high; the next word is
// accepted meanwhile and waits in its last step until the register frees up
`timescale 1ns / 1ps
module sine_pwm_compare_generator_unit #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int ACC_BITS         = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            tick,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     compare_leg_a,
  output logic [15:0]                     compare_leg_b,
  output logic [15:0]                     phase_load
);

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);

  spwm_pkg::cfg_t     cfg;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic               rom_wr_en;
  logic [ADDR_W-1:0]  rom_wr_addr, rom_rd_addr;
  logic signed [15:0] rom_wr_data, rom_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_step       <= spwm_pkg::RST_ANGLE_STEP;
      cfg.modulation_index <= 16'd0;
      cfg.leg_b_offset     <= 16'd0;
      cfg.period_counts    <= spwm_pkg::RST_PERIOD;
      cfg.bridge_phase_deg <= spwm_pkg::RST_BRIDGE_DEG;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spwm_pkg::REG_ANGLE_STEP:   cfg.angle_step       <= cfg_data;
        spwm_pkg::REG_MOD_INDEX:    cfg.modulation_index <= cfg_data[15:0];
        spwm_pkg::REG_LEG_B_OFFSET: cfg.leg_b_offset     <= cfg_data[15:0];
        spwm_pkg::REG_PERIOD:       cfg.period_counts    <= cfg_data[15:0];
        spwm_pkg::REG_BRIDGE_DEG:   cfg.bridge_phase_deg <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  spwm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  spwm_rom #(
    .DEPTH  (SINE_TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_rom (
    .clk     (clk),
    .wr_en   (rom_wr_en),
    .wr_addr (rom_wr_addr),
    .wr_data (rom_wr_data),
    .rd_addr (rom_rd_addr),
    .rd_data (rom_rd_data)
  );

  spwm_seq #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .ACC_BITS         (ACC_BITS),
    .ADDR_W           (ADDR_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .tick          (tick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .compare_leg_a (compare_leg_a),
    .compare_leg_b (compare_leg_b),
    .phase_load    (phase_load),
    .mul_a         (mul_a),
    .mul_b         (mul_b),
    .prod          (prod),
    .rom_wr_en     (rom_wr_en),
    .rom_wr_addr   (rom_wr_addr),
    .rom_wr_data   (rom_wr_data),
    .rom_rd_addr   (rom_rd_addr),
    .rom_rd_data   (rom_rd_data)
  );

endmodule

// File: design/spwm_mul.sv
// shared 32x32 unsigned multiplier with registered product
`timescale 1ns / 1ps
module spwm_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

// File: design/spwm_rom.sv
// sine table memory, one write port and one registered read port
`timescale 1ns / 1ps
module spwm_rom #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic signed [15:0]  wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic signed [15:0]  rd_data
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/spwm_seq.sv
// sequencer: sine table fill after reset, then per-word phase, lookup and compare math
`timescale 1ns / 1ps
module spwm_seq #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int ACC_BITS         = 32,
  parameter int ADDR_W           = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  spwm_pkg::cfg_t            cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      tick,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [15:0]               compare_leg_a,
  output logic [15:0]               compare_leg_b,
  output logic [15:0]               phase_load,
  output logic [31:0]               mul_a,
  output logic [31:0]               mul_b,
  input  logic [63:0]               prod,
  output logic                      rom_wr_en,
  output logic [ADDR_W-1:0]         rom_wr_addr,
  output logic signed [15:0]        rom_wr_data,
  output logic [ADDR_W-1:0]         rom_rd_addr,
  input  logic signed [15:0]        rom_rd_data
);

  typedef enum logic [20:0] {
    S_FX   = 21'h000001,
    S_FX2  = 21'h000002,
    S_FX2D = 21'h000004,
    S_FTM  = 21'h000008,
    S_FTQ  = 21'h000010,
    S_FTC  = 21'h000020,
    S_FS   = 21'h000040,
    S_FM   = 21'h000080,
    S_IDLE = 21'h000100,
    S_IAH  = 21'h000200,
    S_IAL  = 21'h000400,
    S_IBH  = 21'h000800,
    S_IBL  = 21'h001000,
    S_RB   = 21'h002000,
    S_DA   = 21'h004000,
    S_MB   = 21'h008000,
    S_DB   = 21'h010000,
    S_CB   = 21'h020000,
    S_LD   = 21'h040000,
    S_LQ   = 21'h080000,
    S_OUT  = 21'h100000
  } state_t;

  // table sample angle k*2^32/depth kept as quotient and remainder
  localparam logic [31:0] P_STEP     = 32'((64'd1 << 32) / SINE_TABLE_DEPTH);
  localparam logic [17:0] P_REM_STEP = 18'((64'd1 << 32) % SINE_TABLE_DEPTH);
  localparam logic [17:0] DEPTH_W    = 18'(SINE_TABLE_DEPTH);
  localparam logic [17:0] IDX_MAX    = 18'(SINE_TABLE_DEPTH - 1);
  localparam logic [31:0] DEPTH_MUL  = 32'(SINE_TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SINE_TABLE_DEPTH - 1);
  localparam logic [2:0]  LAST_TERM  = 3'(spwm_pkg::NUM_TERMS - 1);

  state_t state, state_next;

  // table fill registers
  logic [ADDR_W-1:0] fill_k;
  logic [31:0]       p;
  logic [17:0]       p_rem;
  logic [31:0]       x, x2, t, q0;
  logic [2:0]        ti;

  // word registers
  logic [ACC_BITS-1:0] angle;
  logic [48:0]         pp;
  logic signed [15:0]  sine_a, sine_b;
  logic [15:0]         cmp_a, cmp_b, load_q;

  // datapath wires
  logic [ACC_BITS+31:0] step_wide;
  logic [ACC_BITS-1:0]  step;
  logic [ACC_BITS+15:0] off_wide;
  logic [ACC_BITS-1:0]  angle_b, angle_sel;
  logic [ACC_BITS+47:0] a48_wide;
  logic [47:0]          a48;
  logic [65:0]          idx_sum;
  logic [17:0]          idx_raw, idx;
  logic [30:0]          r_fold;
  logic [31:0]          rem, qv, term_new;
  logic [46:0]          mag_sum;
  logic [16:0]          mag;
  logic [15:0]          mag16;
  logic [17:0]          p_rem_sum;
  logic                 p_carry;
  logic                 free_out;
  logic                 accept;

  function automatic logic [15:0] abs16(logic signed [15:0] s);
    return s[15] ? 16'(-s) : 16'(s);
  endfunction

  function automatic logic [16:0] duty_of(logic neg, logic [31:0] mp);
    logic [32:0] v;
    if (neg) begin
      v = (mp > spwm_pkg::Q30_ONE) ? 33'd0 : 33'(spwm_pkg::Q30_ONE - mp);
    end else begin
      v = 33'(spwm_pkg::Q30_ONE) + 33'(mp);
    end
    return v[31:15];
  endfunction

  function automatic logic [15:0] cap_cmp(logic [16:0] c, logic [15:0] per);
    return (c > {1'b0, per}) ? per : c[15:0];
  endfunction

  assign step_wide = {cfg.angle_step, {ACC_BITS{1'b0}}};
  assign step      = step_wide[ACC_BITS+31:32];
  assign off_wide  = {cfg.leg_b_offset, {ACC_BITS{1'b0}}};
  assign angle_b   = angle - off_wide[ACC_BITS+15:16];
  assign angle_sel = (state == S_IAH || state == S_IAL) ? angle : angle_b;

  // angle aligned to 48 bits, table index = angle48*depth >> 48 in two partial products
  assign a48_wide = {angle_sel, 48'd0};
  assign a48      = a48_wide[ACC_BITS+47:ACC_BITS];
  assign idx_sum  = {1'b0, pp, 16'd0} + {33'd0, prod[32:0]};
  assign idx_raw  = idx_sum[65:48];
  assign idx      = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;
  assign rom_rd_addr = idx[ADDR_W-1:0];

  // quarter-wave fold of the table sample angle
  assign r_fold = p[30] ? (31'h4000_0000 - {1'b0, p[29:0]}) : {1'b0, p[29:0]};

  // quotient correction of the reciprocal divide
  assign rem      = t - prod[31:0];
  assign qv       = q0 + {31'd0, (rem >= spwm_pkg::term_div(ti))};
  assign term_new = spwm_pkg::Q30_ONE - qv;

  assign mag_sum = prod[46:0] + spwm_pkg::MAG_ROUND;
  assign mag     = mag_sum[46:30];
  assign mag16   = (mag > 17'(spwm_pkg::SINE_FULL)) ? spwm_pkg::SINE_FULL[15:0] : mag[15:0];

  assign rom_wr_en   = (state == S_FM);
  assign rom_wr_addr = fill_k;
  assign rom_wr_data = p[31] ? 16'(-$signed({1'b0, mag16[14:0]})) : $signed(mag16);

  assign p_rem_sum = p_rem + P_REM_STEP;
  assign p_carry   = (p_rem_sum >= DEPTH_W);

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign free_out = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    unique case (state)
      S_FX: begin
        mul_a      = 32'(r_fold);
        mul_b      = spwm_pkg::HALF_PI_Q30;
        state_next = S_FX2;
      end
      S_FX2: begin
        mul_a      = prod[61:30];
        mul_b      = prod[61:30];
        state_next = S_FX2D;
      end
      S_FX2D: begin
        mul_a      = prod[61:30];
        mul_b      = spwm_pkg::Q30_ONE;
        state_next = S_FTM;
      end
      S_FTM: begin
        mul_a      = prod[61:30];
        mul_b      = spwm_pkg::term_recip(ti);
        state_next = S_FTQ;
      end
      S_FTQ: begin
        mul_a      = prod[63:32];
        mul_b      = spwm_pkg::term_div(ti);
        state_next = S_FTC;
      end
      S_FTC: begin
        mul_b = term_new;
        if (ti == LAST_TERM) begin
          mul_a      = x;
          state_next = S_FS;
        end else begin
          mul_a      = x2;
          state_next = S_FTM;
        end
      end
      S_FS: begin
        mul_a      = prod[61:30];
        mul_b      = spwm_pkg::SINE_FULL;
        state_next = S_FM;
      end
      S_FM: begin
        state_next = (fill_k == LAST_ADDR) ? S_IDLE : S_FX;
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_IAH;
        end
      end
      S_IAH: begin
        mul_a      = a48[47:16];
        mul_b      = DEPTH_MUL;
        state_next = S_IAL;
      end
      S_IAL: begin
        mul_a      = 32'(a48[15:0]);
        mul_b      = DEPTH_MUL;
        state_next = S_IBH;
      end
      S_IBH: begin
        mul_a      = a48[47:16];
        mul_b      = DEPTH_MUL;
        state_next = S_IBL;
      end
      S_IBL: begin
        mul_a      = 32'(a48[15:0]);
        mul_b      = DEPTH_MUL;
        state_next = S_RB;
      end
      S_RB: begin
        mul_a      = 32'(cfg.modulation_index);
        mul_b      = 32'(abs16(sine_a));
        state_next = S_DA;
      end
      S_DA: begin
        mul_a      = 32'(cfg.period_counts);
        mul_b      = 32'(duty_of(sine_a[15], prod[31:0]));
        state_next = S_MB;
      end
      S_MB: begin
        mul_a      = 32'(cfg.modulation_index);
        mul_b      = 32'(abs16(sine_b));
        state_next = S_DB;
      end
      S_DB: begin
        mul_a      = 32'(cfg.period_counts);
        mul_b      = 32'(duty_of(sine_b[15], prod[31:0]));
        state_next = S_CB;
      end
      S_CB: begin
        mul_a      = 32'(cfg.bridge_phase_deg);
        mul_b      = 32'(cfg.period_counts);
        state_next = S_LD;
      end
      S_LD: begin
        mul_a      = 32'(prod[23:0]);
        mul_b      = spwm_pkg::RECIP_180;
        state_next = S_LQ;
      end
      S_LQ: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (free_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_FX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FX;
      fill_k    <= '0;
      p         <= 32'd0;
      p_rem     <= 18'd0;
      ti        <= 3'd0;
      angle     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && free_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state) inside
        S_FX2: begin
          x <= prod[61:30];
        end
        S_FX2D: begin
          x2 <= prod[61:30];
          ti <= 3'd0;
        end
        S_FTM: begin
          t <= prod[61:30];
        end
        S_FTQ: begin
          q0 <= prod[63:32];
        end
        S_FTC: begin
          if (ti != LAST_TERM) begin
            ti <= ti + 3'd1;
          end
        end
        S_FM: begin
          fill_k <= fill_k + ADDR_W'(1);
          p      <= p + P_STEP + {31'd0, p_carry};
          p_rem  <= p_carry ? (p_rem_sum - DEPTH_W) : p_rem_sum;
        end
        S_IDLE: begin
          if (accept && tick) begin
            angle <= angle + step;
          end
        end
        S_IAL, S_IBL: begin
          pp <= prod[48:0];
        end
        S_MB: begin
          cmp_a <= cap_cmp(prod[32:16], cfg.period_counts);
        end
        S_CB: begin
          cmp_b <= cap_cmp(prod[32:16], cfg.period_counts);
        end
        S_LQ: begin
          load_q <= (prod[48:32] > 17'h0FFFF) ? 16'hFFFF : prod[47:32];
        end
        S_OUT: begin
          if (free_out) begin
            compare_leg_a <= cmp_a;
            compare_leg_b <= cmp_b;
            phase_load    <= load_q;
          end
        end
        default: begin
        end
      endcase
      // table read data lands in the cycle after the index is formed
      if (state == S_IBL) begin
        sine_a <= rom_rd_data;
      end
      if (state == S_DA) begin
        sine_b <= rom_rd_data;
      end
    end
  end

endmodule

// File: design/spwm_chk.sv
// port-level checker for the sine pwm compare generator, bound to the top level
`timescale 1ns / 1ps
module spwm_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] compare_leg_a,
  input logic [15:0] compare_leg_b,
  input logic [15:0] phase_load
);

  // reset starts the table build: nothing offered, nothing taken
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!out_valid && in_stall))
    else $error("output valid or input open right after reset");

  // one word at a time: an accepted word closes the input
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted a word while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(compare_leg_a) && $stable(compare_leg_b)
                                  && $stable(phase_load)))
    else $error("output word changed while stalled");

endmodule

bind sine_pwm_compare_generator_unit spwm_chk u_spwm_chk (.*);

// File: tb/sv/tb_sine_pwm_compare_generator_unit.sv
// testbench for the sine pwm compare generator: directed table, random words, scoreboard
`timescale 1ns / 1ps
module tb_sine_pwm_compare_generator_unit;

  localparam int LUT_BITS = 10;
  localparam int LUT_DEPTH = 1 << LUT_BITS;
  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam longint unsigned HALF_PI_FIX = 64'd1686629713;
  localparam longint unsigned SINE_PEAK = 64'd32767;
  localparam longint unsigned TAYLOR_DIV [5] = '{110, 72, 42, 20, 6};
  localparam longint DEG_PER_PERIOD = 180;
  localparam logic [spwm_pkg::CFG_IDX_W-1:0] SPARE_IDX = 3'd5;

  localparam int SEGMENTS = 8;
  localparam int WORDS_PER_SEGMENT = 166;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  // the watchdog limit must outlast the table build after reset, which keeps the input stalled
  localparam int STALL_LIMIT = 100000;

  typedef struct packed {
    logic [15:0] leg_a;
    logic [15:0] leg_b;
    logic [15:0] load;
  } duty_word_t;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [spwm_pkg::CFG_IDX_W-1:0]    idx;
    logic [spwm_pkg::CFG_DATA_W-1:0]   data;
    logic                              typed;
    duty_word_t                        want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 39;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [spwm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            tick = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [15:0]                     compare_leg_a;
  logic [15:0]                     compare_leg_b;
  logic [15:0]                     phase_load;

  // model state
  logic [31:0] phase_acc;
  logic [31:0] step_r;
  logic [15:0] mod_r;
  logic [15:0] off_r;
  logic [15:0] period_r;
  logic [7:0]  bridge_r;
  int          sine_lut [LUT_DEPTH];

  duty_word_t pending_compares [$];

  int error_count = 0;
  int words_sent = 0;
  int ticks_low = 0;
  int reg_writes = 0;
  int settings_used = 0;
  int words_checked = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  stim_row_t directed [DIRECTED_ROWS] = '{
    '{ROW_WORD,  '0, 32'd1, 1'b1, '{16'd49, 16'd49, 16'd98}},
    '{ROW_WORD,  '0, 32'd0, 1'b1, '{16'd49, 16'd49, 16'd98}},
    '{ROW_WRITE, spwm_pkg::REG_PERIOD,       32'd0,          1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b1, '{16'd0, 16'd0, 16'd0}},
    '{ROW_WRITE, spwm_pkg::REG_PERIOD,       32'd65535,      1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b1, '{16'd32767, 16'd32767, 16'd65535}},
    '{ROW_WRITE, spwm_pkg::REG_BRIDGE_DEG,   32'd255,        1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b1, '{16'd32767, 16'd32767, 16'd65535}},
    '{ROW_WRITE, spwm_pkg::REG_BRIDGE_DEG,   32'd0,          1'b0, '0},
    '{ROW_WORD,  '0, 32'd0, 1'b1, '{16'd32767, 16'd32767, 16'd0}},
    // quarter-cycle steps walk both legs through every quadrant
    '{ROW_WRITE, spwm_pkg::REG_ANGLE_STEP,   32'h4000_0000,  1'b0, '0},
    '{ROW_WRITE, spwm_pkg::REG_MOD_INDEX,    32'd32768,      1'b0, '0},
    '{ROW_WRITE, spwm_pkg::REG_LEG_B_OFFSET, 32'h0000_4000,  1'b0, '0},
    '{ROW_WRITE, spwm_pkg::REG_PERIOD,       32'd1000,       1'b0, '0},
    '{ROW_WRITE, spwm_pkg::REG_BRIDGE_DEG,   32'd90,         1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    // overmodulation: duty clamps at zero and compare clamps at the period
    '{ROW_WRITE, spwm_pkg::REG_MOD_INDEX,    32'd65535,      1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    '{ROW_WRITE, spwm_pkg::REG_ANGLE_STEP,   32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_WRITE, spwm_pkg::REG_LEG_B_OFFSET, 32'h0000_FFFF,  1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    '{ROW_WORD,  '0, 32'd0, 1'b0, '0},
    '{ROW_WRITE, spwm_pkg::REG_ANGLE_STEP,   32'd0,          1'b0, '0},
    '{ROW_WRITE, spwm_pkg::REG_PERIOD,       32'd1,          1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    // unused register indexes must leave everything alone
    '{ROW_WRITE, SPARE_IDX,                  32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_WRITE, SPARE_IDX + 3'd1,           32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_WRITE, SPARE_IDX + 3'd2,           32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b0, '0},
    // bits above a register's width are dropped
    '{ROW_WRITE, spwm_pkg::REG_PERIOD,       32'hABCD_0064,  1'b0, '0},
    '{ROW_WRITE, spwm_pkg::REG_MOD_INDEX,    32'hFFFF_0000,  1'b0, '0},
    '{ROW_WORD,  '0, 32'd1, 1'b1, '{16'd50, 16'd50, 16'd50}}
  };

  sine_pwm_compare_generator_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .tick          (tick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .compare_leg_a (compare_leg_a),
    .compare_leg_b (compare_leg_b),
    .phase_load    (phase_load)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round(32767*sin(2*pi*k/depth)) via quadrant folding and an odd taylor series in q30
  function automatic int sine_sample(int unsigned k);
    longint unsigned pos, quad, frac, x, x2, term, s, mag;
    pos = (longint'(k) << 32) / LUT_DEPTH;
    quad = (pos >> 30) & 64'd3;
    frac = pos & (Q30 - 64'd1);
    if (quad[0]) frac = Q30 - frac;
    x = (frac * HALF_PI_FIX) >> 30;
    x2 = (x * x) >> 30;
    term = Q30;
    for (int i = 0; i < 5; i++) term = Q30 - ((x2 * term) >> 30) / TAYLOR_DIV[i];
    s = (x * term) >> 30;
    mag = (s * SINE_PEAK + (Q30 >> 1)) >> 30;
    if (mag > SINE_PEAK) mag = SINE_PEAK;
    return (quad >= 64'd2) ? -int'(mag) : int'(mag);
  endfunction

  function automatic logic [15:0] duty_compare(int sample);
    longint m_l, p_l, v, duty, cmp;
    m_l = mod_r;
    p_l = period_r;
    v = m_l * sample + longint'(Q30);
    if (v < 0) v = 0;
    duty = v >>> 15;
    cmp = (p_l * duty) >>> 16;
    if (cmp > p_l) cmp = p_l;
    return cmp[15:0];
  endfunction

  function automatic duty_word_t predict_compares(bit advance);
    duty_word_t w;
    logic [31:0] angle_b;
    longint b_l, p_l, load_l;
    if (advance) phase_acc = phase_acc + step_r;
    angle_b = phase_acc - {off_r, 16'h0000};
    b_l = bridge_r;
    p_l = period_r;
    load_l = (b_l * p_l) / DEG_PER_PERIOD;
    if (load_l > 65535) load_l = 65535;
    w.leg_a = duty_compare(sine_lut[phase_acc[31 -: LUT_BITS]]);
    w.leg_b = duty_compare(sine_lut[angle_b[31 -: LUT_BITS]]);
    w.load = load_l[15:0];
    return w;
  endfunction

  task automatic write_reg(logic [spwm_pkg::CFG_IDX_W-1:0] idx,
                           logic [spwm_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      spwm_pkg::REG_ANGLE_STEP:   step_r = data;
      spwm_pkg::REG_MOD_INDEX:    mod_r = data[15:0];
      spwm_pkg::REG_LEG_B_OFFSET: off_r = data[15:0];
      spwm_pkg::REG_PERIOD:       period_r = data[15:0];
      spwm_pkg::REG_BRIDGE_DEG:   bridge_r = data[7:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // entered and left at a falling edge; valid stays high unless a gap is drawn
  task automatic send_word(bit tick_bit, bit use_typed, duty_word_t typed_word);
    duty_word_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    tick <= tick_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_compares(tick_bit);
    pending_compares.push_back(use_typed ? typed_word : predicted);
    words_sent++;
    if (!tick_bit) ticks_low++;
    @(negedge clk);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_compares.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] with_junk(logic [31:0] value, int width);
    return ($urandom() << width) | value;
  endfunction

  task automatic shuffle_settings();
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      2: v = $urandom();
      3: v = $urandom_range(1, 1 << 24);
      default: v = spwm_pkg::RST_ANGLE_STEP;
    endcase
    write_reg(spwm_pkg::REG_ANGLE_STEP, v);
    case ($urandom_range(4))
      0: v = 32'd0;
      1: v = 32'd32768;
      2: v = 32'd65535;
      3: v = $urandom_range(0, 32768);
      default: v = $urandom_range(0, 65535);
    endcase
    write_reg(spwm_pkg::REG_MOD_INDEX, with_junk(v, 16));
    case ($urandom_range(2))
      0: v = 32'd0;
      1: v = 32'hFFFF;
      default: v = $urandom_range(0, 65535);
    endcase
    write_reg(spwm_pkg::REG_LEG_B_OFFSET, with_junk(v, 16));
    case ($urandom_range(4))
      0: v = 32'd0;
      1: v = 32'd1;
      2: v = 32'd65535;
      3: v = $urandom_range(1, 65535);
      default: v = $urandom_range(1, 200);
    endcase
    write_reg(spwm_pkg::REG_PERIOD, with_junk(v, 16));
    case ($urandom_range(3))
      0: v = 32'd0;
      1: v = 32'd180;
      2: v = 32'd255;
      default: v = $urandom_range(0, 180);
    endcase
    write_reg(spwm_pkg::REG_BRIDGE_DEG, with_junk(v, 8));
    write_reg(SPARE_IDX + 3'($urandom_range(2)), $urandom());
    settings_used++;
  endtask

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    duty_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_compares.size() == 0) begin
        $error("output word with nothing expected: %0d %0d %0d",
               compare_leg_a, compare_leg_b, phase_load);
        error_count++;
      end else begin
        exp_w = pending_compares.pop_front();
        check_field("compare_leg_a", exp_w.leg_a, compare_leg_a);
        check_field("compare_leg_b", exp_w.leg_b, compare_leg_b);
        check_field("phase_load", exp_w.load, phase_load);
        words_checked++;
      end
    end
  end

  // output side: random stall, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    phase_acc = '0;
    step_r = spwm_pkg::RST_ANGLE_STEP;
    mod_r = '0;
    off_r = '0;
    period_r = spwm_pkg::RST_PERIOD;
    bridge_r = spwm_pkg::RST_BRIDGE_DEG;
    for (int k = 0; k < LUT_DEPTH; k++) sine_lut[k] = sine_sample(k);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed[r].kind == ROW_WRITE) begin
        drain_block();
        write_reg(directed[r].idx, directed[r].data);
      end else begin
        send_word(directed[r].data[0], directed[r].typed, directed[r].want);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_block();
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      shuffle_settings();
      // long output hold while words keep coming, so the block backs up
      if (seg == 0) hold_request = 1'b1;
      repeat (WORDS_PER_SEGMENT) send_word($urandom_range(9) != 0, 1'b0, '0);
    end

    drain_block();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d words (%0d without tick), %0d register writes, %0d random settings",
             words_sent, ticks_low, reg_writes, settings_used);
    $display("%0d result words checked under four idle/stall mixes and one long output hold",
             words_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
design/spwm_pkg.sv
design/spwm_mul.sv
design/spwm_rom.sv
design/spwm_seq.sv
design/sine_pwm_compare_generator_unit.sv
design/spwm_chk.sv
tb/sv/tb_sine_pwm_compare_generator_unit.sv
